// File: hdl/gll_pkg.sv
package gll_pkg;

  localparam int CoordW    = 20;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int InTdataW  = 112;
  localparam int OutTdataW = 96;

  localparam int AdvW        = 20;
  localparam int AdvFracBits = 6;
  localparam int AdvPxW      = AdvW - AdvFracBits;
  localparam int DistW       = AdvPxW + 32 - 16;
  localparam int OffW        = 32;
  localparam int SizeProdW   = 12 + 24 - 8;

  localparam logic [15:0] NewlineCode = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GLYPH_SCALE  = 3'd0,
    CFG_X_UNIT_SCALE = 3'd1,
    CFG_Y_UNIT_SCALE = 3'd2,
    CFG_TEXT_HEIGHT  = 3'd3,
    CFG_LINE_ADVANCE = 3'd4,
    CFG_BOX_WIDTH    = 3'd5,
    CFG_BOX_HEIGHT   = 3'd6,
    CFG_LAYOUT_MODE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0]       glyph_scale;
    logic [31:0]       x_unit_scale;
    logic [31:0]       y_unit_scale;
    logic [CoordW-1:0] text_height;
    logic [CoordW-1:0] line_advance;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic              nl_en;
    logic              wrap_en;
  } cfg_t;

  typedef struct packed {
    logic              first_char;
    logic [15:0]       char_code;
    logic [AdvW-1:0]   advance_64ths;
    logic [15:0]       bearing_x;
    logic [15:0]       bearing_y;
    logic [11:0]       glyph_width;
    logic [11:0]       glyph_height;
    logic [15:0]       texture_id;
  } item_t;

  typedef struct packed {
    logic                 first_char;
    logic                 is_newline;
    logic                 has_glyph;
    logic [DistW-1:0]     adv_step;
    logic [OffW-1:0]      offx_mag;
    logic                 offx_neg;
    logic [OffW-1:0]      offy_mag;
    logic                 offy_neg;
    logic [SizeProdW-1:0] width_prod;
    logic [SizeProdW-1:0] height_prod;
    logic [15:0]          texture_id;
  } scaled_t;

endpackage

// File: hdl/gll_scale.sv
module gll_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gll_pkg::cfg_t   cfg_i,
  input  logic            load_i,
  input  logic            valid_i,
  input  gll_pkg::item_t  item_i,
  output logic            valid_o,
  output gll_pkg::scaled_t scaled_o
);
  import gll_pkg::*;

  logic [AdvPxW-1:0]       adv_px;
  logic [AdvPxW+32-1:0]    dist_prod;
  logic [15:0]             bx_mag, by_mag;
  logic [47:0]             offx_prod, offy_prod;
  logic [35:0]             w_prod, h_prod;
  logic                    valid_q;
  scaled_t                 scaled_d, scaled_q;

  assign adv_px    = item_i.advance_64ths[AdvW-1:AdvFracBits];
  assign dist_prod = (AdvPxW+32)'(adv_px) * (AdvPxW+32)'(cfg_i.x_unit_scale);
  assign bx_mag    = item_i.bearing_x[15] ? 16'(-item_i.bearing_x) : item_i.bearing_x;
  assign by_mag    = item_i.bearing_y[15] ? 16'(-item_i.bearing_y) : item_i.bearing_y;
  assign offx_prod = 48'(bx_mag) * 48'(cfg_i.x_unit_scale);
  assign offy_prod = 48'(by_mag) * 48'(cfg_i.y_unit_scale);
  assign w_prod    = 36'(item_i.glyph_width) * 36'(cfg_i.glyph_scale);
  assign h_prod    = 36'(item_i.glyph_height) * 36'(cfg_i.glyph_scale);

  always_comb begin
    scaled_d.first_char  = item_i.first_char;
    scaled_d.is_newline  = (item_i.char_code == NewlineCode);
    scaled_d.has_glyph   = (item_i.glyph_width != 12'd0);
    scaled_d.adv_step    = dist_prod[AdvPxW+32-1:16];
    scaled_d.offx_mag    = offx_prod[47:16];
    scaled_d.offx_neg    = item_i.bearing_x[15];
    scaled_d.offy_mag    = offy_prod[47:16];
    scaled_d.offy_neg    = item_i.bearing_y[15];
    scaled_d.width_prod  = w_prod[35:8];
    scaled_d.height_prod = h_prod[35:8];
    scaled_d.texture_id  = item_i.texture_id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign valid_o  = valid_q;
  assign scaled_o = scaled_q;

endmodule

// File: hdl/gll_pen.sv
module gll_pen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gll_pkg::cfg_t             cfg_i,
  input  logic                      valid_i,
  input  gll_pkg::scaled_t          scaled_i,
  output logic                      free_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [gll_pkg::OutTdataW-1:0] out_data_o
);
  import gll_pkg::*;

  localparam logic signed [33:0] SMax = 34'sd524287;
  localparam logic signed [33:0] SMin = -34'sd524288;

  function automatic logic [CoordW-1:0] sat_u(input logic [30:0] v);
    sat_u = (|v[30:CoordW]) ? '1 : v[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] sat_s(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v;
    if (v > SMax) t = SMax;
    if (v < SMin) t = SMin;
    sat_s = t[CoordW-1:0];
  endfunction

  logic [CoordW-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic              stop_q, stop_d;
  logic [CoordW-1:0] pen_x_c, pen_y_c, base_x, base_y, y_sat;
  logic              stop_c, emit, y_over, x_over;
  logic [CoordW:0]   y_sum;
  logic [30:0]       x_sum;
  logic signed [33:0] px, py;
  logic [CoordW-1:0] sw, sh;
  logic              out_valid_q;
  logic [OutTdataW-1:0] out_data_q;
  logic              proc;

  assign free_o = !out_valid_q || out_ready_i;
  assign proc   = valid_i && free_o;

  assign pen_x_c = scaled_i.first_char ? '0 : pen_x_q;
  assign pen_y_c = scaled_i.first_char ? cfg_i.text_height : pen_y_q;
  assign stop_c  = scaled_i.first_char ? 1'b0 : stop_q;

  assign y_sum  = {1'b0, pen_y_c} + {1'b0, cfg_i.line_advance};
  assign y_sat  = y_sum[CoordW] ? '1 : y_sum[CoordW-1:0];
  assign y_over = y_sum > {1'b0, cfg_i.box_height};
  assign x_sum  = 31'(pen_x_c) + 31'(scaled_i.adv_step);
  assign x_over = x_sum > 31'(cfg_i.box_width);

  always_comb begin
    pen_x_d = pen_x_c;
    pen_y_d = pen_y_c;
    stop_d  = stop_c;
    base_x  = pen_x_c;
    base_y  = pen_y_c;
    emit    = 1'b0;
    if (!stop_c) begin
      if (scaled_i.is_newline && cfg_i.nl_en) begin
        pen_x_d = '0;
        pen_y_d = y_sat;
        stop_d  = y_over;
      end else if (x_over && !cfg_i.wrap_en) begin
        stop_d = 1'b1;
      end else if (x_over && y_over) begin
        pen_x_d = '0;
        pen_y_d = y_sat;
        stop_d  = 1'b1;
      end else begin
        if (x_over) begin
          base_x  = '0;
          base_y  = y_sat;
          pen_x_d = sat_u(31'(scaled_i.adv_step));
        end else begin
          pen_x_d = sat_u(x_sum);
        end
        pen_y_d = base_y;
        emit    = scaled_i.has_glyph;
      end
    end
  end

  always_comb begin
    if (scaled_i.offx_neg) begin
      px = $signed({14'd0, base_x}) - $signed({2'd0, scaled_i.offx_mag});
    end else begin
      px = $signed({14'd0, base_x}) + $signed({2'd0, scaled_i.offx_mag});
    end
    if (scaled_i.offy_neg) begin
      py = $signed({14'd0, base_y}) + $signed({2'd0, scaled_i.offy_mag});
    end else begin
      py = $signed({14'd0, base_y}) - $signed({2'd0, scaled_i.offy_mag});
    end
  end

  assign sw = (|scaled_i.width_prod[SizeProdW-1:CoordW]) ? '1
            : scaled_i.width_prod[CoordW-1:0];
  assign sh = (|scaled_i.height_prod[SizeProdW-1:CoordW]) ? '1
            : scaled_i.height_prod[CoordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (proc) begin
        pen_x_q <= pen_x_d;
        pen_y_q <= pen_y_d;
        stop_q  <= stop_d;
      end
      if (free_o) begin
        out_valid_q <= proc && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_data_q <= {scaled_i.texture_id, sh, sw, sat_s(py), sat_s(px)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/glyph_line_layout_top.sv
// Glyph line layout: takes one character with its glyph metrics per transaction and
// places it in the text box, wrapping at character granularity or stopping as
// layout_mode selects. Throughput is one character per clock unless the output is
// stalled; each character passes the input register, the multiply stage and the pen
// stage with the output register. The pen position and stopped flag are updated in
// the pen stage by one add and compare per character, which sets that rate.
// Characters that give no result (newlines, blanks, stopped or wrapped-out glyphs)
// produce no output transaction. Write configuration only while the block is idle.
module glyph_line_layout_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [gll_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gll_pkg::CfgDataW-1:0]   cfg_data_i,

  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // char_code[15:0], advance_64ths[35:16], bearing_x[51:36], bearing_y[67:52],
  // glyph_width[79:68], glyph_height[91:80], texture_id[107:92], zero pad
  input  logic [gll_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // first_char
  input  logic                           s_axis_tuser_i,

  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // pos_x[19:0], pos_y[39:20], screen_width[59:40], screen_height[79:60],
  // glyph_texture[95:80]
  output logic [gll_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import gll_pkg::*;

  cfg_t    cfg_q;
  item_t   s1_q, s1_d;
  logic    s1_valid_q;
  logic    s2_valid, s2_free, pen_free;
  scaled_t s2_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GLYPH_SCALE:  cfg_q.glyph_scale  <= cfg_data_i[23:0];
        CFG_X_UNIT_SCALE: cfg_q.x_unit_scale <= cfg_data_i;
        CFG_Y_UNIT_SCALE: cfg_q.y_unit_scale <= cfg_data_i;
        CFG_TEXT_HEIGHT:  cfg_q.text_height  <= cfg_data_i[CoordW-1:0];
        CFG_LINE_ADVANCE: cfg_q.line_advance <= cfg_data_i[CoordW-1:0];
        CFG_BOX_WIDTH:    cfg_q.box_width    <= cfg_data_i[CoordW-1:0];
        CFG_BOX_HEIGHT:   cfg_q.box_height   <= cfg_data_i[CoordW-1:0];
        CFG_LAYOUT_MODE: begin
          cfg_q.wrap_en <= cfg_data_i[0];
          cfg_q.nl_en   <= cfg_data_i[1];
        end
      endcase
    end
  end

  assign s2_free         = !s2_valid || pen_free;
  assign s_axis_tready_o = !s1_valid_q || s2_free;

  always_comb begin
    s1_d.first_char    = s_axis_tuser_i;
    s1_d.char_code     = s_axis_tdata_i[15:0];
    s1_d.advance_64ths = s_axis_tdata_i[35:16];
    s1_d.bearing_x     = s_axis_tdata_i[51:36];
    s1_d.bearing_y     = s_axis_tdata_i[67:52];
    s1_d.glyph_width   = s_axis_tdata_i[79:68];
    s1_d.glyph_height  = s_axis_tdata_i[91:80];
    s1_d.texture_id    = s_axis_tdata_i[107:92];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_q <= s1_d;
    end
  end

  gll_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .load_i   (s2_free),
    .valid_i  (s1_valid_q),
    .item_i   (s1_q),
    .valid_o  (s2_valid),
    .scaled_o (s2_data)
  );

  gll_pen u_pen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (s2_valid),
    .scaled_i    (s2_data),
    .free_o      (pen_free),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// File: hdl/gll_checker.sv
module gll_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_o,
  input  logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic [gll_pkg::OutTdataW-1:0]  m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output transaction changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o && !in_acc) ##1 (!m_axis_tvalid_o && !in_acc)
      ##1 (!m_axis_tvalid_o && !in_acc) |=> !m_axis_tvalid_o)
    else $error("output transaction without input");

endmodule

bind glyph_line_layout_top gll_checker u_gll_checker (.*);

// File: tb/sv/glyph_line_layout_top_tb.sv
module glyph_line_layout_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gll_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int IdlePct = 23;

  typedef enum int {
    LAYOUT_TYPICAL,
    LAYOUT_ZERO,
    LAYOUT_MAX,
    LAYOUT_NOISE
  } layout_kind_e;

  // same bit order as m_axis_tdata_o, pos_x in the lowest bits
  typedef struct packed {
    logic [15:0]       texture;
    logic [CoordW-1:0] screen_h;
    logic [CoordW-1:0] screen_w;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_x;
  } placed_glyph_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CFG_GLYPH_SCALE;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 s_axis_tuser_i = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  // layout state as the block should hold it
  cfg_t              layout_cfg = '0;
  logic [CoordW-1:0] pen_x = '0;
  logic [CoordW-1:0] pen_y = '0;
  bit                halted = 1'b0;

  placed_glyph_t pending_glyphs[$];
  bit            no_idle = 1'b0;
  int            n_errors = 0;
  int            n_chars = 0;
  int            n_placed = 0;
  int            n_layouts = 0;
  int            stall_cycles = 0;

  glyph_line_layout_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [CoordW-1:0] clamp_u20(input logic [63:0] v);
    return (v > 64'hFFFFF) ? 20'hFFFFF : v[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] clamp_s20(input longint v);
    if (v > 524287) return 20'h7FFFF;
    if (v < -524288) return 20'h80000;
    return 20'(v);
  endfunction

  // magnitude scaled and truncated, sign restored afterwards
  function automatic longint bearing_offset(input logic [15:0] b, input logic [31:0] s);
    longint      sb;
    logic [63:0] mag;
    sb = longint'($signed(b));
    mag = (sb < 0) ? -sb : sb;
    mag = (mag * s) >> 16;
    return (sb < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  task automatic lay_out_char(input item_t c);
    logic [63:0]   adv_step;
    logic [63:0]   y_next;
    placed_glyph_t g;
    if (c.first_char) begin
      pen_x = '0;
      pen_y = layout_cfg.text_height;
      halted = 1'b0;
    end
    if (halted) return;
    if (c.char_code == NewlineCode && layout_cfg.nl_en) begin
      y_next = 64'(pen_y) + layout_cfg.line_advance;
      pen_x = '0;
      pen_y = clamp_u20(y_next);
      if (y_next > layout_cfg.box_height) halted = 1'b1;
      return;
    end
    adv_step = ((64'(c.advance_64ths) >> AdvFracBits) * layout_cfg.x_unit_scale) >> 16;
    if (64'(pen_x) + adv_step > layout_cfg.box_width) begin
      if (!layout_cfg.wrap_en) begin
        halted = 1'b1;
        return;
      end
      y_next = 64'(pen_y) + layout_cfg.line_advance;
      pen_x = '0;
      pen_y = clamp_u20(y_next);
      if (y_next > layout_cfg.box_height) begin
        halted = 1'b1;
        return;
      end
    end
    if (c.glyph_width != 0) begin
      g.pos_x = clamp_s20(longint'(pen_x)
                          + bearing_offset(c.bearing_x, layout_cfg.x_unit_scale));
      g.pos_y = clamp_s20(longint'(pen_y)
                          - bearing_offset(c.bearing_y, layout_cfg.y_unit_scale));
      g.screen_w = clamp_u20((64'(c.glyph_width) * layout_cfg.glyph_scale) >> 8);
      g.screen_h = clamp_u20((64'(c.glyph_height) * layout_cfg.glyph_scale) >> 8);
      g.texture = c.texture_id;
      pending_glyphs = {pending_glyphs, g};
    end
    pen_x = clamp_u20(64'(pen_x) + adv_step);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_glyphs
    placed_glyph_t exp_g;
    placed_glyph_t got_g;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_g = m_axis_tdata_o;
      if (pending_glyphs.size() == 0) begin
        $error("output transaction with no glyph pending: 0x%0h", m_axis_tdata_o);
        n_errors++;
      end else begin
        exp_g = pending_glyphs.pop_front();
        check_field("pos_x", exp_g.pos_x, got_g.pos_x);
        check_field("pos_y", exp_g.pos_y, got_g.pos_y);
        check_field("screen_width", exp_g.screen_w, got_g.screen_w);
        check_field("screen_height", exp_g.screen_h, got_g.screen_h);
        check_field("glyph_texture", exp_g.texture, got_g.texture);
        n_placed++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o)
        || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $error("no transaction for %0d cycles, %0d glyphs pending", StallLimit,
             pending_glyphs.size());
      $display("glyph_line_layout_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic send_char(input item_t c);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'd0, c.texture_id, c.glyph_height, c.glyph_width,
                        c.bearing_y, c.bearing_x, c.advance_64ths, c.char_code};
    s_axis_tuser_i  <= c.first_char;
    do @(posedge clk_i); while (!s_axis_tready_o);
    lay_out_char(c);
    n_chars++;
  endtask

  // always waits for a clock edge first so tvalid is never lowered and raised in one step
  task automatic hold_off();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_glyphs.size() != 0) @(posedge clk_i);
  endtask

  // characters with no result may still be in the pipe after the last glyph
  task automatic settle();
    hold_off();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_layout(input cfg_t c);
    logic [CfgDataW-1:0] val;
    cfg_idx_e            idx;
    settle();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_GLYPH_SCALE:  val = 32'(c.glyph_scale);
        CFG_X_UNIT_SCALE: val = c.x_unit_scale;
        CFG_Y_UNIT_SCALE: val = c.y_unit_scale;
        CFG_TEXT_HEIGHT:  val = 32'(c.text_height);
        CFG_LINE_ADVANCE: val = 32'(c.line_advance);
        CFG_BOX_WIDTH:    val = 32'(c.box_width);
        CFG_BOX_HEIGHT:   val = 32'(c.box_height);
        default:          val = {30'd0, c.nl_en, c.wrap_en};
      endcase
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    layout_cfg = c;
    n_layouts++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // 16 px of advance is 1/16 of a unit, eight such glyphs to a line
  function automatic cfg_t base_layout(input logic [1:0] mode);
    cfg_t c;
    c.glyph_scale  = 24'h001000;
    c.x_unit_scale = 32'h0100_0000;
    c.y_unit_scale = 32'h0100_0000;
    c.text_height  = 20'h01000;
    c.line_advance = 20'h01400;
    c.box_width    = 20'h08000;
    c.box_height   = 20'h04000;
    {c.nl_en, c.wrap_en} = mode;
    return c;
  endfunction

  function automatic cfg_t pick_layout(input layout_kind_e kind, input logic [1:0] mode);
    cfg_t        c;
    logic [63:0] wide;
    c = '0;
    case (kind)
      LAYOUT_TYPICAL: begin
        c.text_height  = 20'($urandom_range(20'h30000, 20'h800));
        c.line_advance = c.text_height + 20'($urandom_range(c.text_height / 2));
        wide = 64'(c.text_height) + 64'(c.line_advance) * $urandom_range(8, 1);
        c.box_height = clamp_u20(wide);
        c.box_width = 20'($urandom_range(20'hFFFFF, 20'h2000));
        // about 2 to 30 average glyphs to a line
        wide = (64'(c.box_width) << 16) / (20 * $urandom_range(30, 2));
        c.x_unit_scale = wide[31:0];
        wide = (64'(c.text_height) << 16) / $urandom_range(64, 8);
        c.y_unit_scale = wide[31:0];
        wide = (64'(c.text_height) << 8) / $urandom_range(64, 8);
        c.glyph_scale = wide[23:0];
      end
      LAYOUT_ZERO: c = '0;
      LAYOUT_MAX:  c = '1;
      default: begin
        c.glyph_scale  = 24'($urandom);
        c.x_unit_scale = $urandom;
        c.y_unit_scale = $urandom;
        c.text_height  = 20'($urandom);
        c.line_advance = 20'($urandom);
        c.box_width    = 20'($urandom);
        c.box_height   = 20'($urandom);
      end
    endcase
    {c.nl_en, c.wrap_en} = mode;
    return c;
  endfunction

  function automatic item_t glyph_item(input logic first, input logic [15:0] code,
                                       input logic [19:0] adv, input logic [15:0] bx,
                                       input logic [15:0] by, input logic [11:0] gw,
                                       input logic [11:0] gh, input logic [15:0] tex);
    item_t c;
    c.first_char    = first;
    c.char_code     = code;
    c.advance_64ths = adv;
    c.bearing_x     = bx;
    c.bearing_y     = by;
    c.glyph_width   = gw;
    c.glyph_height  = gh;
    c.texture_id    = tex;
    return c;
  endfunction

  function automatic item_t typical_char(input logic first);
    item_t c;
    c.first_char    = first;
    c.char_code     = ($urandom_range(9) == 0) ? NewlineCode : 16'($urandom_range(126, 32));
    c.advance_64ths = 20'($urandom_range(40) * 64 + $urandom_range(63));
    c.bearing_x     = 16'($urandom_range(20)) - 16'd4;
    c.bearing_y     = 16'($urandom_range(50)) - 16'd10;
    c.glyph_width   = ($urandom_range(5) == 0) ? 12'd0 : 12'($urandom_range(48));
    c.glyph_height  = 12'($urandom_range(64));
    c.texture_id    = 16'($urandom);
    return c;
  endfunction

  function automatic item_t noise_item();
    logic [127:0] r;
    item_t        c;
    r = {$urandom, $urandom, $urandom, $urandom};
    c = r[$bits(item_t)-1:0];
    return c;
  endfunction

  task automatic run_phase(input int n, input int noise_pct, input bit pause_mid);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if (pause_mid && sent >= n / 2) begin
        hold_off();
        pause_mid = 1'b0;
      end
      if ($urandom_range(99) < noise_pct) begin
        send_char(noise_item());
        sent++;
      end else begin
        len = $urandom_range(40, 1);
        for (int k = 0; k < len && sent < n; k++) begin
          send_char(typical_char(k == 0));
          sent++;
        end
      end
    end
  endtask

  // pen at the origin until the first string starts, reset registers then typical ones
  task automatic test_unstarted();
    send_char(glyph_item(1'b0, 16'h0041, 20'd1029, 16'd1, 16'd12, 12'd10, 12'd12, 16'h0001));
    send_char(glyph_item(1'b0, 16'h0042, 20'd1024, 16'hFFFE, 16'd9, 12'd8, 12'd9, 16'h0002));
    load_layout(base_layout(2'b11));
    send_char(glyph_item(1'b0, 16'h0043, 20'd1024, 16'd2, 16'd10, 12'd9, 12'd10, 16'h0003));
  endtask

  task automatic test_newline_handling();
    load_layout(base_layout(2'b11));
    send_char(glyph_item(1'b1, 16'h0048, 20'd1024, 16'd1, 16'd12, 12'd10, 12'd12, 16'h0010));
    send_char(glyph_item(1'b0, NewlineCode, 20'd1024, 16'd0, 16'd0, 12'd5, 12'd5, 16'h0011));
    // blank glyph still moves the pen
    send_char(glyph_item(1'b0, 16'h0020, 20'd1024, 16'd0, 16'd0, 12'd0, 12'd0, 16'h0012));
    send_char(glyph_item(1'b0, 16'h0069, 20'd512, 16'd1, 16'd11, 12'd3, 12'd11, 16'h0013));
    send_char(glyph_item(1'b0, NewlineCode, 20'd0, 16'd0, 16'd0, 12'd0, 12'd0, 16'h0014));
    send_char(glyph_item(1'b0, NewlineCode, 20'd0, 16'd0, 16'd0, 12'd0, 12'd0, 16'h0015));
    send_char(glyph_item(1'b0, 16'h0067, 20'd1024, 16'd0, 16'hFFFC, 12'd9, 12'd14, 16'h0016));
    // the newline just before g already went past the box height, so this one is ignored
    send_char(glyph_item(1'b0, NewlineCode, 20'd0, 16'd0, 16'd0, 12'd0, 12'd0, 16'h0017));
    send_char(glyph_item(1'b0, 16'h0078, 20'd1024, 16'd1, 16'd8, 12'd9, 12'd8, 16'h0018));
  endtask

  task automatic test_unhandled_newline();
    load_layout(base_layout(2'b01));
    send_char(glyph_item(1'b1, NewlineCode, 20'd1024, 16'd1, 16'd2, 12'd8, 12'd2, 16'h0020));
    load_layout(base_layout(2'b00));
    send_char(glyph_item(1'b1, NewlineCode, 20'd1024, 16'd1, 16'd2, 12'd8, 12'd2, 16'h0021));
  endtask

  task automatic test_wrap_and_stop();
    load_layout(base_layout(2'b01));
    send_char(glyph_item(1'b1, 16'h0057, 20'd4096, 16'd1, 16'd12, 12'd60, 12'd12, 16'h0030));
    send_char(glyph_item(1'b0, 16'h0057, 20'd4096, 16'd1, 16'd12, 12'd60, 12'd12, 16'h0031));
    send_char(glyph_item(1'b0, 16'h0057, 20'd4097, 16'd1, 16'd12, 12'd60, 12'd12, 16'h0032));
    // wider than the whole box, still placed after the wrap
    send_char(glyph_item(1'b0, 16'h004D, 20'd12800, 16'd0, 16'd12, 12'd300, 12'd12, 16'h0033));
    send_char(glyph_item(1'b0, 16'h0061, 20'd1024, 16'd1, 16'd8, 12'd9, 12'd8, 16'h0034));
    send_char(glyph_item(1'b0, 16'h0062, 20'd1024, 16'd1, 16'd8, 12'd9, 12'd8, 16'h0035));
    load_layout(base_layout(2'b00));
    send_char(glyph_item(1'b1, 16'h004D, 20'd12800, 16'd0, 16'd12, 12'd300, 12'd12, 16'h0036));
    send_char(glyph_item(1'b0, 16'h0061, 20'd1024, 16'd1, 16'd8, 12'd9, 12'd8, 16'h0037));
  endtask

  task automatic test_field_extremes();
    load_layout(pick_layout(LAYOUT_MAX, 2'b11));
    send_char(glyph_item(1'b1, 16'hFFFF, 20'd0, 16'h8000, 16'h7FFF, 12'hFFF, 12'hFFF,
                         16'hFFFF));
    send_char(glyph_item(1'b0, 16'h0000, 20'd0, 16'h7FFF, 16'h8000, 12'h001, 12'h000,
                         16'h0000));
    // newline from a saturated pen runs past the box height
    send_char(glyph_item(1'b0, NewlineCode, 20'd0, 16'd0, 16'd0, 12'd1, 12'd1, 16'h0040));
    send_char(glyph_item(1'b1, 16'h0041, 20'hFFFFF, 16'd0, 16'd0, 12'hFFF, 12'hFFF,
                         16'h0041));
  endtask

  task automatic test_random_layouts();
    for (int p = 0; p < 12; p++) begin
      load_layout(pick_layout(LAYOUT_TYPICAL, 2'(p)));
      no_idle = (p == 3);
      run_phase(100, 10, p == 6);
    end
    no_idle = 1'b0;
    load_layout(pick_layout(LAYOUT_ZERO, 2'b11));
    run_phase(50, 20, 1'b0);
    load_layout(pick_layout(LAYOUT_MAX, 2'b01));
    run_phase(50, 20, 1'b0);
    load_layout(pick_layout(LAYOUT_NOISE, 2'($urandom)));
    run_phase(60, 50, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unstarted();
    test_newline_handling();
    test_unhandled_newline();
    test_wrap_and_stop();
    test_field_extremes();
    test_random_layouts();
    settle();
    $display("summary: %0d characters over %0d register settings, %0d placed glyphs checked",
             n_chars, n_layouts, n_placed);
    $display("summary: all layout modes, wraps, stops, newlines, blanks and saturation hit");
    if (n_errors == 0) begin
      $display("glyph_line_layout_top_tb: PASS");
    end else begin
      $display("glyph_line_layout_top_tb: FAIL");
    end
    $finish;
  end

endmodule
